// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the point-in-polygon RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pip_pkg.sv =====
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants for the point-in-polygon test block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pip_pkg;

    // Width of the coordinate ports
    localparam int FIELD_W = 32;

    // Width of the vertex count register and its reset value
    localparam int          VCOUNT_W   = 4;
    localparam logic [3:0]  VCOUNT_RST = 4'd4;

    // Fewest vertices that make a polygon
    localparam int MIN_VERTICES = 3;

    // Request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TEST = 1'b1;

    // Control that travels with one edge into the edge unit
    typedef struct packed {
        logic vld;   // edge (j, i) present this cycle
        logic last;  // closing edge of the polygon
    } t_edge_ctl;

    // Status back from the edge unit
    typedef struct packed {
        logic done;    // all edges of the test have been folded in
        logic parity;  // crossing parity
    } t_edge_stat;

endpackage

// ===== rtl/pip_edge_unit.sv =====
// ----------------------------------------------------------------------------
// pip_edge_unit
// Shared edge crossing unit: differences, multiplier pair, exact compare and
// crossing-parity accumulator. Takes one edge per cycle, three stages deep.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pip_edge_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  pip_pkg::t_edge_ctl            i_ctl,
    input  logic signed [COORD_WIDTH-1:0] i_px,
    input  logic signed [COORD_WIDTH-1:0] i_py,
    input  logic signed [COORD_WIDTH-1:0] i_xi,
    input  logic signed [COORD_WIDTH-1:0] i_yi,
    input  logic signed [COORD_WIDTH-1:0] i_xj,
    input  logic signed [COORD_WIDTH-1:0] i_yj,
    output pip_pkg::t_edge_stat           o_stat
);

    localparam int DW = COORD_WIDTH + 1;  // difference width
    localparam int PW = 2 * DW;           // product width

    // Stage 1: differences and straddle flag
    logic signed [DW-1:0] w_dxp, w_dy, w_dxe, w_dyp;
    logic                 w_straddle;

    assign w_dxp      = DW'(i_px) - DW'(i_xi);
    assign w_dy       = DW'(i_yj) - DW'(i_yi);
    assign w_dxe      = DW'(i_xj) - DW'(i_xi);
    assign w_dyp      = DW'(i_py) - DW'(i_yi);
    assign w_straddle = (i_yi > i_py) != (i_yj > i_py);

    logic                 r_s1_vld, r_s1_last, r_s1_strad;
    logic signed [DW-1:0] r_dxp, r_dy, r_dxe, r_dyp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctl.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last  <= i_ctl.last;
        r_s1_strad <= w_straddle;
        r_dxp      <= w_dxp;
        r_dy       <= w_dy;
        r_dxe      <= w_dxe;
        r_dyp      <= w_dyp;
    end

    // Stage 2: multiplier pair, direction of compare from sign of dy
    logic                 r_s2_vld, r_s2_last, r_s2_strad, r_s2_dpos;
    logic signed [PW-1:0] r_lhs, r_rhs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last  <= r_s1_last;
        r_s2_strad <= r_s1_strad;
        r_s2_dpos  <= !r_dy[DW-1] && (r_dy != '0);
        r_lhs      <= r_dxp * r_dy;
        r_rhs      <= r_dxe * r_dyp;
    end

    // Stage 3: exact compare, toggle parity on a crossing
    logic w_left;
    assign w_left = r_s2_dpos ? (r_lhs < r_rhs) : (r_rhs < r_lhs);

    logic r_acc, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_s2_vld && r_s2_last;
            if (i_clear) begin
                r_acc <= 1'b0;
            end else if (r_s2_vld && r_s2_strad && w_left) begin
                r_acc <= !r_acc;
            end
        end
    end

    assign o_stat.done   = r_done;
    assign o_stat.parity = r_acc;

    // A finish flag only follows a closing edge in the product stage
    `ASSERT_SAME(a_done_from_last, i_clk, i_rst_n, r_done, $past(r_s2_vld) && $past(r_s2_last), "done without closing edge")
    // Parity is only disturbed by a valid product stage or a clear
    `ASSERT_NEXT(a_acc_quiet, i_clk, i_rst_n, !r_s2_vld && !i_clear, $stable(r_acc), "parity changed with no edge")
    // Products only become valid after differences were valid
    `ASSERT_NEXT(a_pipe_order, i_clk, i_rst_n, !r_s1_vld, !r_s2_vld, "product stage valid without difference stage")

endmodule

// ===== rtl/point_in_polygon_test.sv =====
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Crossing-number point-in-polygon test on a stored Q16.16 polygon.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start while busy is low. i_func selects a vertex load
//   (i_vertex_index, i_coord_x, i_coord_y written to the vertex table) or a
//   point test (i_coord_x, i_coord_y are the point). A load gives no result,
//   and loads to a slot at or above MAX_VERTICES are dropped.
//   A test gives one o_inside_res, shown for exactly one cycle with o_valid.
//   The receiver cannot stall; the result must be taken in that cycle.
//   vertex_count is written through i_cfg_we / i_cfg_wdata; the user must write
//   it only while idle, which the block does not enforce. A count above MAX_VERTICES is clamped.
// Test sequence:
//   With n vertices in use (n >= 3) a test makes n + 1 table reads (closing
//   vertex first, one per cycle from the single read port) that feed a
//   three-stage edge unit that owns the one multiplier pair, then the result
//   register that strobes o_valid. busy is high meanwhile and drops as
//   o_valid rises, so the next request can enter in that cycle.
//   With fewer than three vertices the result (outside) shows the next cycle.
// Reset:
//   Control and vertex_count (to 4) are reset; the vertex table is not and
//   must be loaded before a test reads it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module point_in_polygon_test #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [2:0]                        i_vertex_index,
    input  logic signed [pip_pkg::FIELD_W-1:0] i_coord_x,
    input  logic signed [pip_pkg::FIELD_W-1:0] i_coord_y,
    // result channel
    output logic                              o_valid,
    output logic                              o_inside_res,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [pip_pkg::VCOUNT_W-1:0]      i_cfg_wdata
);

    localparam int AW = $clog2(MAX_VERTICES);      // table address width
    localparam int NW = $clog2(MAX_VERTICES + 1);  // vertex count width
    localparam int CW = COORD_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_n;
    logic          r_valid, n_valid;
    logic          r_inside, n_inside;
    logic [pip_pkg::VCOUNT_W-1:0] r_vertex_count;

    logic signed [CW-1:0] r_px, r_py;

    logic w_accept, w_test, w_clear, w_we, w_issue, w_wr_ok;
    logic [NW-1:0] w_n_eff, w_nm1, w_idx;
    logic [AW-1:0] w_rd_addr, w_wr_addr;

    pip_pkg::t_edge_ctl  w_ctl;
    pip_pkg::t_edge_stat w_stat;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_test   = (i_func == pip_pkg::FUNC_TEST);

    // Count in use, clamped to the table depth
    assign w_n_eff = (32'(r_vertex_count) > 32'(MAX_VERTICES)) ?
                     NW'(MAX_VERTICES) : NW'(r_vertex_count);

    // Load slot check
    assign w_wr_ok   = (32'(i_vertex_index) < 32'(MAX_VERTICES));
    assign w_wr_addr = AW'(i_vertex_index);

    // Read order: closing vertex n-1, then 0 .. n-1
    assign w_nm1     = r_n - NW'(1);
    assign w_idx     = (r_cnt == '0) ? w_nm1 : (r_cnt - NW'(1));
    assign w_rd_addr = w_idx[AW-1:0];

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= pip_pkg::VCOUNT_RST;
        end else if (i_cfg_we) begin
            r_vertex_count <= i_cfg_wdata;
        end
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        n_inside = r_inside;
        w_clear  = 1'b0;
        w_we     = 1'b0;
        w_issue  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_test) begin
                        w_clear = 1'b1;
                        if (w_n_eff < NW'(pip_pkg::MIN_VERTICES)) begin
                            n_valid  = 1'b1;
                            n_inside = 1'b0;
                        end else begin
                            n_state = S_RUN;
                            n_cnt   = '0;
                        end
                    end else begin
                        w_we = w_wr_ok;
                    end
                end
            end
            S_RUN: begin
                w_issue = 1'b1;
                n_cnt   = r_cnt + NW'(1);
                if (r_cnt == r_n) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_stat.done) begin
                    n_valid  = 1'b1;
                    n_inside = w_stat.parity;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // Test point and count latched at request
    always_ff @(posedge i_clk) begin
        r_inside <= n_inside;
        if (w_accept && w_test) begin
            r_px <= i_coord_x[CW-1:0];
            r_py <= i_coord_y[CW-1:0];
            r_n  <= w_n_eff;
        end
    end

    assign o_valid      = r_valid;
    assign o_inside_res = r_inside;

    // Vertex table: {y, x}, one write and one registered read port
    logic [2*CW-1:0] r_mem [MAX_VERTICES];
    logic [2*CW-1:0] r_rd_data;
    logic            r_rd_vld, r_rd_first, r_rd_last;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= {i_coord_y[CW-1:0], i_coord_x[CW-1:0]};
        end
        if (w_issue) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= w_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_first <= (r_cnt == '0);
        r_rd_last  <= (r_cnt == r_n);
    end

    // Previous vertex (j end of the edge)
    logic signed [CW-1:0] r_prev_x, r_prev_y, w_cur_x, w_cur_y;

    assign w_cur_x = r_rd_data[CW-1:0];
    assign w_cur_y = r_rd_data[2*CW-1:CW];

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_prev_x <= w_cur_x;
            r_prev_y <= w_cur_y;
        end
    end

    assign w_ctl.vld  = r_rd_vld && !r_rd_first;
    assign w_ctl.last = r_rd_last;

    pip_edge_unit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (w_clear),
        .i_ctl   (w_ctl),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_xi    (w_cur_x),
        .i_yi    (w_cur_y),
        .i_xj    (r_prev_x),
        .i_yj    (r_prev_y),
        .o_stat  (w_stat)
    );

    // Short polygon answers outside on the next cycle
    `ASSERT_NEXT(a_short_test, i_clk, i_rst_n, w_accept && w_test && (w_n_eff < NW'(pip_pkg::MIN_VERTICES)), o_valid && !o_inside_res, "short polygon test not answered outside")
    // A load request never produces a result
    `ASSERT_NEXT(a_load_silent, i_clk, i_rst_n, w_accept && !w_test, !o_valid, "result after load request")
    // The block is idle whenever a result is shown
    `ASSERT_SAME(a_idle_on_result, i_clk, i_rst_n, o_valid, !busy, "result while busy")
    // Busy ends only by delivering a result
    `ASSERT_SAME(a_busy_ends, i_clk, i_rst_n, $fell(busy), o_valid, "busy dropped without result")

endmodule
